### rtl/core/crc16rpc_pkg.sv
// ----------------------------------------------------------------------------
// crc16rpc_pkg
// Shared types, constants and the byte-wide crc update for the response
// packet checker.
// ----------------------------------------------------------------------------
package crc16rpc_pkg;

   // crc polynomial, data bits enter lsb first, initial value zero
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // packet count limits (count includes itself and two crc bytes)
   localparam logic [7:0] MIN_PACKET = 8'd3;
   localparam logic [7:0] MAX_PACKET = 8'd64;

   // width of the packet position and count state
   localparam int unsigned POS_W = 7;

   // one result transaction
   typedef struct packed {
      logic        packet_end;
      logic        crc_ok;
      logic        length_error;
      logic [15:0] crc_value;
   } result_type;

   // crc update over one byte, lsb of the data first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_cur,
                                            input logic [7:0]  data);
      logic [15:0] crc_nxt;
      logic        fb;
      crc_nxt = crc_cur;
      for (int i = 0; i < 8; i++) begin
         fb      = data[i] ^ crc_nxt[15];
         crc_nxt = {crc_nxt[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return crc_nxt;
   endfunction

endpackage

### rtl/core/crc16rpc_engine.sv
// ----------------------------------------------------------------------------
// crc16rpc_engine
// Packet parse state and crc accumulation; turns one accepted byte into one
// result in the same cycle and updates the packet state at the clock edge.
// ----------------------------------------------------------------------------
module crc16rpc_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   output crc16rpc_pkg::result_type result
);
   import crc16rpc_pkg::*;

   logic [15:0]      crc_accum_ff, crc_accum_in;
   logic [POS_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic [POS_W-1:0] packet_total_ff, packet_total_in;
   logic [7:0]       received_crc_low_ff, received_crc_low_in;

   logic [15:0] crc_upd;
   logic [7:0]  pos_plus2;
   logic [7:0]  total_ext;

   assign crc_upd   = crc_byte(bytes_seen_ff == '0 ? CRC_INIT : crc_accum_ff, data_byte);
   assign pos_plus2 = {1'b0, bytes_seen_ff} + 8'd2;
   assign total_ext = {1'b0, packet_total_ff};

   // next state and result for the byte on the input
   always_comb begin
      crc_accum_in        = crc_accum_ff;
      bytes_seen_in       = bytes_seen_ff;
      packet_total_in     = packet_total_ff;
      received_crc_low_in = received_crc_low_ff;
      result              = '0;
      if (bytes_seen_ff == '0) begin
         if (data_byte < MIN_PACKET || data_byte > MAX_PACKET) begin
            // rejected count byte ends the packet at once
            result.packet_end   = 1'b1;
            result.length_error = 1'b1;
            crc_accum_in        = CRC_INIT;
         end else begin
            crc_accum_in     = crc_upd;
            packet_total_in  = data_byte[POS_W-1:0];
            bytes_seen_in    = POS_W'(1);
            result.crc_value = crc_upd;
         end
      end else begin
         result.crc_value = crc_accum_ff;
         if (pos_plus2 < total_ext) begin
            // payload byte, shows the crc including this byte
            crc_accum_in     = crc_upd;
            bytes_seen_in    = bytes_seen_ff + POS_W'(1);
            result.crc_value = crc_upd;
         end else if (pos_plus2 == total_ext) begin
            // low crc byte
            received_crc_low_in = data_byte;
            bytes_seen_in       = bytes_seen_ff + POS_W'(1);
         end else begin
            // high crc byte closes the packet
            result.packet_end = 1'b1;
            result.crc_ok     = (received_crc_low_ff == crc_accum_ff[7:0]) &&
                                (data_byte == crc_accum_ff[15:8]);
            crc_accum_in      = CRC_INIT;
            bytes_seen_in     = '0;
         end
      end
   end

   // packet state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_accum_ff        <= CRC_INIT;
         bytes_seen_ff       <= '0;
         packet_total_ff     <= '0;
         received_crc_low_ff <= '0;
      end else if (take) begin
         crc_accum_ff        <= crc_accum_in;
         bytes_seen_ff       <= bytes_seen_in;
         packet_total_ff     <= packet_total_in;
         received_crc_low_ff <= received_crc_low_in;
      end
   end

   // inside a packet the position never reaches the count
   a_pos_below_total: assert property (@(posedge clock) disable iff (reset)
      (bytes_seen_ff == '0) || (bytes_seen_ff < packet_total_ff))
      else $error("packet position ran past the count");

   // a packet in progress always holds a legal count
   a_total_legal: assert property (@(posedge clock) disable iff (reset)
      (bytes_seen_ff != '0) |-> (total_ext >= MIN_PACKET && total_ext <= MAX_PACKET))
      else $error("packet in progress with illegal count");

   // a packet end always returns the parser to the count byte
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && result.packet_end) |=> (bytes_seen_ff == '0 && crc_accum_ff == CRC_INIT))
      else $error("parser did not restart after packet end");

endmodule

### rtl/core/crc16rpc_skid.sv
// ----------------------------------------------------------------------------
// crc16rpc_skid
// Result register with one skid entry, so a new byte is taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
module crc16rpc_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  crc16rpc_pkg::result_type in_result,
   output logic                     out_valid,
   input  logic                     out_ready,
   output crc16rpc_pkg::result_type out_result
);
   import crc16rpc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_take;

   assign out_take   = out_valid_ff && out_ready;
   assign in_ready   = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;

   // output and skid entry control
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // the skid entry only fills behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a held skid entry moves to the output when the output is taken
   a_skid_moves: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_take) |=> (out_valid_ff && !skid_valid_ff &&
                                       out_data_ff == $past(skid_data_ff)))
      else $error("skid entry lost on output take");

endmodule

### rtl/core/crc16_response_packet_checker_unit.sv
// ----------------------------------------------------------------------------
// crc16_response_packet_checker_unit
// CRC-16 checker for count-prefixed response packets.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one result transaction, registered in the
// output register or the skid entry; a byte is accepted in every cycle while
// the skid entry is empty: the unrolled eight-step crc update over one byte is
// combinational; req_tready stays high while one result waits on rsp. The first
// byte of a packet is its count (count byte, payload, two crc bytes); a count
// below 3 or above 64 ends the packet on that byte with length_error set.
// CRC-16 polynomial 0x8005, initial value 0, data lsb first, no final xor.
// rsp_tlast marks packet end; on it crc_ok tells whether the received crc
// (low byte first) matched.
// ----------------------------------------------------------------------------
module crc16_response_packet_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] crc_value
   output logic [1:0]  rsp_tuser,   // [0] crc_ok, [1] length_error
   output logic        rsp_tlast    // packet_end
);
   import crc16rpc_pkg::*;

   logic       req_take;
   result_type eng_result;
   result_type rsp_result;

   assign req_take = req_tvalid && req_tready;

   // packet parse and crc
   crc16rpc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_tdata),
      .result    (eng_result)
   );

   // result register and skid entry
   crc16rpc_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_take),
      .in_ready   (req_tready),
      .in_result  (eng_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // output packing
   assign rsp_tdata = rsp_result.crc_value;
   assign rsp_tuser = {rsp_result.length_error, rsp_result.crc_ok};
   assign rsp_tlast = rsp_result.packet_end;

   // status flags only appear at packet end
   a_flags_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1])) |-> rsp_tlast)
      else $error("status flag without packet end");

endmodule
